// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the complex square root block.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define CSQ_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CSQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`else

`define CSQ_ASSERT_NOW(label, clk, rst_n, pre, post)
`define CSQ_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/core/csq_pkg.sv =====
// Package for the complex square root block: default format constants.
// Depends on nothing.
`timescale 1ns / 1ps

package csq_pkg;

	// Default sample format, signed Q2.14.
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

endpackage

// ===== rtl/core/csq_sqrt_cell.sv =====
// One cell of the integer square root chain: settles one root bit per word.
// Depends on nothing; the top level strings these cells into two rows.
`timescale 1ns / 1ps

module csq_sqrt_cell #(
	parameter int RAD_W  = 64,
	parameter int SIDE_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_vld,
	input  logic [RAD_W-1:0]       up_rad,
	input  logic [RAD_W/2:0]       up_rem,
	input  logic [RAD_W/2-1:0]     up_root,
	input  logic [SIDE_W-1:0]      up_side,
	output logic                   dn_vld,
	output logic [RAD_W-1:0]       dn_rad,
	output logic [RAD_W/2:0]       dn_rem,
	output logic [RAD_W/2-1:0]     dn_root,
	output logic [SIDE_W-1:0]      dn_side
);

	localparam int RW = RAD_W / 2;

	logic [RW+2:0]  cur;
	logic [RW+2:0]  trial;
	logic [RW+2:0]  diff;
	logic           ge;
	logic           vld_q;
	logic [RAD_W-1:0] rad_q;
	logic [RW:0]    rem_q;
	logic [RW-1:0]  root_q;
	logic [SIDE_W-1:0] side_q;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		cur   = {up_rem, up_rad[RAD_W-1 -: 2]};
		trial = {1'b0, up_root, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	// Valid flag of the word held in this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= up_vld;
		end
	end

	// Partial remainder, root and side data move on every cycle.
	always_ff @(posedge clk) begin
		rad_q  <= up_rad << 2;
		rem_q  <= ge ? diff[RW:0] : cur[RW:0];
		root_q <= {up_root[RW-2:0], ge};
		side_q <= up_side;
	end

	assign dn_vld  = vld_q;
	assign dn_rad  = rad_q;
	assign dn_rem  = rem_q;
	assign dn_root = root_q;
	assign dn_side = side_q;

endmodule

// ===== rtl/core/csq_div_cell.sv =====
// One cell of the restoring divider chain: settles one quotient bit per word.
// Depends on nothing; the top level strings these cells into a row.
`timescale 1ns / 1ps

module csq_div_cell #(
	parameter int DIV_W  = 31,
	parameter int QUO_W  = 16,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_vld,
	input  logic [DIV_W-1:0]     up_div,
	input  logic [DIV_W-1:0]     up_rem,
	input  logic [QUO_W-1:0]     up_num,
	input  logic [QUO_W-1:0]     up_quo,
	input  logic [SIDE_W-1:0]    up_side,
	output logic                 dn_vld,
	output logic [DIV_W-1:0]     dn_div,
	output logic [DIV_W-1:0]     dn_rem,
	output logic [QUO_W-1:0]     dn_num,
	output logic [QUO_W-1:0]     dn_quo,
	output logic [SIDE_W-1:0]    dn_side
);

	logic [DIV_W:0]   cur;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic             vld_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [SIDE_W-1:0] side_q;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		cur  = {up_rem, up_num[QUO_W-1]};
		diff = cur - {1'b0, up_div};
		ge   = (cur >= {1'b0, up_div});
	end

	// Valid flag of the word held in this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= up_vld;
		end
	end

	// Remainder, dividend bits, quotient and side data move every cycle.
	always_ff @(posedge clk) begin
		div_q  <= up_div;
		rem_q  <= ge ? diff[DIV_W-1:0] : cur[DIV_W-1:0];
		num_q  <= up_num << 1;
		quo_q  <= {up_quo[QUO_W-2:0], ge};
		side_q <= up_side;
	end

	assign dn_vld  = vld_q;
	assign dn_div  = div_q;
	assign dn_rem  = rem_q;
	assign dn_num  = num_q;
	assign dn_quo  = quo_q;
	assign dn_side = side_q;

endmodule

// ===== rtl/core/complex_square_root.sv =====
// Top level of the principal complex square root: input stages, two
// square root cell rows, a divider cell row and the output stage.
// Depends on csq_pkg, csq_sqrt_cell, csq_div_cell and assert_macros.svh.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+--------------------------------
//  input   | x_re, x_im, last_in           | start high while busy low
//  result  | y_re, y_im, last_out          | done strobe, one cycle, no stall
//
// One word enters every cycle; busy never rises. Each word passes the input
// stages, root row 1, stage 4, root row 2, stage 5, the divider row and the
// output stage; the rows are chains of one-bit cells (default format Q2.14).
// Reset clears only the valid flags of the stage registers and of the cells.
// The receiver cannot stall; each result shows for one cycle with done.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module complex_square_root
	import csq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] x_re,
	input  logic signed [DATA_WIDTH-1:0] x_im,
	input  logic                         last_in,
	output logic                         done,
	output logic        [DATA_WIDTH-2:0] y_re,
	output logic signed [DATA_WIDTH-1:0] y_im,
	output logic                         last_out
);

	// Guard bit counts and internal widths.
	localparam int HEAD_RAW = 61 - DATA_WIDTH - FRAC_BITS;
	localparam int XTRA     = (HEAD_RAW < 0) ? 0 :
		(((HEAD_RAW / 2) > 16) ? 16 : (HEAD_RAW / 2));
	localparam int GUARD_A  = 32 - DATA_WIDTH;
	localparam int GUARD_B  = FRAC_BITS + 2 * XTRA - 1;
	localparam int GUARD_C  = (GUARD_A < GUARD_B) ? GUARD_A : GUARD_B;
	localparam int GUARD    = (GUARD_C > 16) ? 16 : ((GUARD_C < 0) ? 0 : GUARD_C);
	localparam int LH_SHIFT = FRAC_BITS - GUARD + 2 * XTRA - 1;
	localparam int MW       = DATA_WIDTH;
	localparam int QW       = 2 * DATA_WIDTH;
	localparam int V1       = QW + 2 * GUARD;
	localparam int RW1      = V1 / 2;
	localparam int SW       = ((RW1 > MW + GUARD) ? RW1 : (MW + GUARD)) + 1;
	localparam int V2       = SW + LH_SHIFT;
	localparam int V2E      = V2 + (V2 % 2);
	localparam int RW2      = V2E / 2;
	localparam int NW       = MW + FRAC_BITS + XTRA + 1;
	localparam int DVW      = RW2 + 1;
	localparam int QB       = DATA_WIDTH;
	localparam int NC1      = RW1;
	localparam int NC2      = RW2;
	localparam int SIDE1_W  = 2 * MW + 3;
	localparam int SIDE2_W  = MW + 3;
	localparam int SIDE3_W  = MW + 4;
	localparam int LAT      = 6 + NC1 + NC2 + QB;
	localparam logic [RW2:0] HALF = (RW2 + 1)'((1 << XTRA) >> 1);

	// Stage 1: magnitudes and signs.
	logic            vld_s1;
	logic [MW-1:0]   ma_s1, nb_s1;
	logic            an_s1, bn_s1, last_s1;
	// Stage 2: squares.
	logic            vld_s2;
	logic [QW-1:0]   sqa_s2, sqb_s2;
	logic [MW-1:0]   ma_s2, nb_s2;
	logic            an_s2, bn_s2, last_s2;
	// Stage 3: squared modulus.
	logic            vld_s3;
	logic [QW-1:0]   q_s3;
	logic [MW-1:0]   ma_s3, nb_s3;
	logic            an_s3, bn_s3, last_s3;
	// Stage 4: modulus plus real magnitude.
	logic            vld_s4;
	logic [SW-1:0]   s_s4;
	logic [MW-1:0]   nb_s4;
	logic            an_s4, bn_s4, last_s4;
	// Stage 5: rounded large part and divider setup.
	logic            vld_s5;
	logic [MW-1:0]   big_s5;
	logic [DVW-1:0]  div_s5, rem_s5;
	logic [QB-1:0]   num_s5;
	logic            zero_s5, an_s5, bn_s5, last_s5;
	// Stage 6: output word.
	logic            vld_s6;
	logic [MW-1:0]   yre_s6, yim_s6;
	logic            last_s6;

	// Links between cells of the three rows.
	logic               v1_vld  [NC1+1];
	logic [V1-1:0]      v1_rad  [NC1+1];
	logic [RW1:0]       v1_rem  [NC1+1];
	logic [RW1-1:0]     v1_root [NC1+1];
	logic [SIDE1_W-1:0] v1_side [NC1+1];
	logic               v2_vld  [NC2+1];
	logic [V2E-1:0]     v2_rad  [NC2+1];
	logic [RW2:0]       v2_rem  [NC2+1];
	logic [RW2-1:0]     v2_root [NC2+1];
	logic [SIDE2_W-1:0] v2_side [NC2+1];
	logic               d_vld   [QB+1];
	logic [DVW-1:0]     d_div   [QB+1];
	logic [DVW-1:0]     d_rem   [QB+1];
	logic [QB-1:0]      d_num   [QB+1];
	logic [QB-1:0]      d_quo   [QB+1];
	logic [SIDE3_W-1:0] d_side  [QB+1];

	logic [MW-1:0]   ma_in, nb_in;
	logic [MW-1:0]   r1_ma, r1_nb, r2_nb, r3_big;
	logic            r1_an, r1_bn, r1_last, r2_an, r2_bn, r2_last;
	logic            r3_an, r3_bn, r3_last, r3_zero;
	logic [RW2-1:0]  lh;
	logic [RW2:0]    lh_sum;
	logic [NW-1:0]   num_full;
	logic [MW-1:0]   sml_mag;
	logic [MW-1:0]   yre_n, yim_n;

	assign busy = 1'b0;

	// Valid flags of the stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= v1_vld[NC1];
			vld_s5 <= v2_vld[NC2];
			vld_s6 <= d_vld[QB];
		end
	end

	// Magnitudes of the two input parts.
	assign ma_in = x_re[DATA_WIDTH-1] ? (~x_re + 1'b1) : x_re;
	assign nb_in = x_im[DATA_WIDTH-1] ? (~x_im + 1'b1) : x_im;

	// Input stages: magnitudes, squares and their sum.
	always_ff @(posedge clk) begin
		ma_s1   <= ma_in;
		nb_s1   <= nb_in;
		an_s1   <= x_re[DATA_WIDTH-1];
		bn_s1   <= x_im[DATA_WIDTH-1];
		last_s1 <= last_in;
		sqa_s2  <= ma_s1 * ma_s1;
		sqb_s2  <= nb_s1 * nb_s1;
		ma_s2   <= ma_s1;
		nb_s2   <= nb_s1;
		an_s2   <= an_s1;
		bn_s2   <= bn_s1;
		last_s2 <= last_s1;
		q_s3    <= sqa_s2 + sqb_s2;
		ma_s3   <= ma_s2;
		nb_s3   <= nb_s2;
		an_s3   <= an_s2;
		bn_s3   <= bn_s2;
		last_s3 <= last_s2;
	end

	// First root row: modulus with GUARD extra fraction bits.
	assign v1_vld[0]  = vld_s3;
	assign v1_rad[0]  = V1'(q_s3) << (2 * GUARD);
	assign v1_rem[0]  = '0;
	assign v1_root[0] = '0;
	assign v1_side[0] = {ma_s3, nb_s3, an_s3, bn_s3, last_s3};

	for (genvar k = 0; k < NC1; k++) begin : g_root1
		csq_sqrt_cell #(.RAD_W(V1), .SIDE_W(SIDE1_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_vld  (v1_vld[k]),
			.up_rad  (v1_rad[k]),
			.up_rem  (v1_rem[k]),
			.up_root (v1_root[k]),
			.up_side (v1_side[k]),
			.dn_vld  (v1_vld[k+1]),
			.dn_rad  (v1_rad[k+1]),
			.dn_rem  (v1_rem[k+1]),
			.dn_root (v1_root[k+1]),
			.dn_side (v1_side[k+1])
		);
	end

	assign {r1_ma, r1_nb, r1_an, r1_bn, r1_last} = v1_side[NC1];

	// Modulus plus the real magnitude.
	always_ff @(posedge clk) begin
		s_s4    <= SW'(v1_root[NC1]) + (SW'(r1_ma) << GUARD);
		nb_s4   <= r1_nb;
		an_s4   <= r1_an;
		bn_s4   <= r1_bn;
		last_s4 <= r1_last;
	end

	// Second root row: square root of half the sum, XTRA extra bits.
	assign v2_vld[0]  = vld_s4;
	assign v2_rad[0]  = V2E'(s_s4) << LH_SHIFT;
	assign v2_rem[0]  = '0;
	assign v2_root[0] = '0;
	assign v2_side[0] = {nb_s4, an_s4, bn_s4, last_s4};

	for (genvar k = 0; k < NC2; k++) begin : g_root2
		csq_sqrt_cell #(.RAD_W(V2E), .SIDE_W(SIDE2_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_vld  (v2_vld[k]),
			.up_rad  (v2_rad[k]),
			.up_rem  (v2_rem[k]),
			.up_root (v2_root[k]),
			.up_side (v2_side[k]),
			.dn_vld  (v2_vld[k+1]),
			.dn_rad  (v2_rad[k+1]),
			.dn_rem  (v2_rem[k+1]),
			.dn_root (v2_root[k+1]),
			.dn_side (v2_side[k+1])
		);
	end

	assign {r2_nb, r2_an, r2_bn, r2_last} = v2_side[NC2];
	assign lh       = v2_root[NC2];
	assign lh_sum   = (RW2 + 1)'(lh) + HALF;
	assign num_full = (NW'(r2_nb) << (FRAC_BITS + XTRA)) + NW'(lh);

	// Round the large part and set up the divider.
	always_ff @(posedge clk) begin
		big_s5  <= MW'(lh_sum >> XTRA);
		div_s5  <= {lh, 1'b0};
		rem_s5  <= DVW'(num_full >> QB);
		num_s5  <= num_full[QB-1:0];
		zero_s5 <= (lh == '0);
		an_s5   <= r2_an;
		bn_s5   <= r2_bn;
		last_s5 <= r2_last;
	end

	// Divider row: imaginary magnitude over twice the root, rounded.
	assign d_vld[0]  = vld_s5;
	assign d_div[0]  = div_s5;
	assign d_rem[0]  = rem_s5;
	assign d_num[0]  = num_s5;
	assign d_quo[0]  = '0;
	assign d_side[0] = {big_s5, zero_s5, an_s5, bn_s5, last_s5};

	for (genvar k = 0; k < QB; k++) begin : g_div
		csq_div_cell #(.DIV_W(DVW), .QUO_W(QB), .SIDE_W(SIDE3_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_vld  (d_vld[k]),
			.up_div  (d_div[k]),
			.up_rem  (d_rem[k]),
			.up_num  (d_num[k]),
			.up_quo  (d_quo[k]),
			.up_side (d_side[k]),
			.dn_vld  (d_vld[k+1]),
			.dn_div  (d_div[k+1]),
			.dn_rem  (d_rem[k+1]),
			.dn_num  (d_num[k+1]),
			.dn_quo  (d_quo[k+1]),
			.dn_side (d_side[k+1])
		);
	end

	assign {r3_big, r3_zero, r3_an, r3_bn, r3_last} = d_side[QB];

	// Place the two parts by quadrant; a zero input gives zero.
	always_comb begin
		sml_mag = r3_zero ? '0 : d_quo[QB];
		if (!r3_an) begin
			yre_n = r3_big;
			yim_n = r3_bn ? (~sml_mag + 1'b1) : sml_mag;
		end else begin
			yre_n = sml_mag;
			yim_n = r3_bn ? (~r3_big + 1'b1) : r3_big;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		yre_s6  <= yre_n;
		yim_s6  <= yim_n;
		last_s6 <= r3_last;
	end

	assign done     = vld_s6;
	assign y_re     = yre_s6[DATA_WIDTH-2:0];
	assign y_im     = yim_s6;
	assign last_out = last_s6;

	// Every result traces back to an accepted word, flag intact.
	`CSQ_ASSERT_NOW(a_done_src, clk, arst_n, done, $past(start, LAT))
	`CSQ_ASSERT_NOW(a_last_pass, clk, arst_n, done, last_out == $past(last_in, LAT))
	`CSQ_ASSERT_NOW(a_zero_in, clk, arst_n,
		done && $past(x_re == '0 && x_im == '0, LAT), y_re == '0 && y_im == '0)

endmodule
